@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/gda_pkg.sv @@
package gda_pkg;

    // Field widths of the transfer payloads
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 16;
    localparam int DIFF_W  = 23;
    localparam int MSTART_W = 9;

    // Month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Operation codes
    localparam logic FUNC_DIFF = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;

    // Day-number constants
    localparam int DAYS_PER_YEAR = 365;

    // Divider by a century: multiply by ceil(2^19 / 100) and keep the top bits,
    // exact for every dividend below 43690
    localparam int DIV_W       = YEAR_W;
    localparam int DIVISOR     = 100;
    localparam int REM_W       = 7;
    localparam int RECIP       = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = DIV_W + RECIP_W;
    localparam logic [REM_W-1:0] REM_LAST  = REM_W'(DIVISOR - 1);

    typedef struct packed {
        logic               func;
        logic [YEAR_W-1:0]  year_a;
        logic [MONTH_W-1:0] month_a;
        logic [DAY_W-1:0]   day_a;
        logic [YEAR_W-1:0]  year_b;
        logic [MONTH_W-1:0] month_b;
        logic [DAY_W-1:0]   day_b;
        logic [COUNT_W-1:0] add_count;
    } gda_in_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] day_diff;
        logic                     a_not_after_b;
        logic [YEAR_W-1:0]        sum_year;
        logic [MONTH_W-1:0]       sum_month;
        logic [DAY_W-1:0]         sum_day;
    } gda_out_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
        logic [REM_W-1:0]   remainder;
    } div_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_D_MUL,
        S_D_DAY,
        S_D_Q4,
        S_D_DIVS,
        S_D_DIVW,
        S_D_Q100,
        S_D_Q400,
        S_A_DIVS,
        S_A_DIVW,
        S_A_STEP,
        S_FINISH
    } state_t;

    // Force a month code into January..December
    function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        if (m < MONTH_JAN)
            r = MONTH_JAN;
        else if (m > MONTH_DEC)
            r = MONTH_DEC;
        else
            r = m;
        return r;
    endfunction

    // Days before the first of a month in a common year
    function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MSTART_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Length of a month, February stretched in leap years
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m) inside
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: r = 5'd30;
            MONTH_FEB: r = leap ? 5'd29 : 5'd28;
            default:   r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/gregorian_date_arithmetic_top.sv @@
// Gregorian date unit. A transfer is taken when start is high and busy is low;
// busy then stays high until the result is ready, and the result is shown for
// one cycle with done high, so the receiver must take it in that cycle. func 0
// builds both day numbers term by term through one shared adder, with the
// century counts from a reciprocal-multiply divider that answers in the cycle
// after launch. func 1 runs the divider once on the start year and then
// subtracts one month length per cycle until the total no longer exceeds the
// current month. done rises in the same cycle that busy falls. A new transfer
// may be taken in the same cycle that done is high.
module gregorian_date_arithmetic_top #(
    parameter int MAX_ADD_DAYS = 65535
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gda_pkg::gda_in_t  item,
    output logic              done,
    output gda_pkg::gda_out_t result
);
    import gda_pkg::*;

    // Running day total and accumulator widths
    localparam int TW = $clog2(MAX_ADD_DAYS + 32);
    localparam int AW = (TW > DIFF_W) ? TW : DIFF_W;
    // Unwrapped year needs room for the whole added span
    localparam int YW = $clog2((1 << YEAR_W) + (MAX_ADD_DAYS + 31) / 365 + 2);

    state_t             state_reg, state_next;
    logic               sel_b_reg;
    gda_in_t            req_reg;
    logic [AW-1:0]      acc_reg;
    logic [YW-1:0]      yr_reg;
    logic [MONTH_W-1:0] mon_reg;
    logic [REM_W-1:0]   rem100_reg;
    logic [1:0]         q4_reg;
    logic               le_reg;
    gda_out_t           res_reg;
    logic               done_reg;

    logic               accept;
    logic [YEAR_W-1:0]  cur_y;
    logic [MONTH_W-1:0] cur_m;
    logic [DAY_W-1:0]   cur_d;
    logic [YEAR_W-1:0]  ly;
    logic [DAY_W-1:0]   start_day;
    logic [TW-1:0]      cnt_sat;
    logic [TW-1:0]      total_init;
    logic               leap;

    logic [AW-1:0]      alu_b;
    logic               alu_sub;
    logic [AW-1:0]      alu_result;
    logic               alu_borrow;
    logic               alu_zero;
    logic               step_go;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    div_res_t           div_res;

    assign accept = start && (state_reg == S_IDLE);

    // Select the date being folded into the day number
    always_comb
    begin
        cur_y = sel_b_reg ? req_reg.year_b : req_reg.year_a;
        cur_m = clamp_month(sel_b_reg ? req_reg.month_b : req_reg.month_a);
        cur_d = sel_b_reg ? req_reg.day_b : req_reg.day_a;
        if (cur_m <= MONTH_FEB)
            ly = (cur_y != '0) ? cur_y - 1'b1 : '0;
        else
            ly = cur_y;
    end

    // Seed the running total for the add operation
    always_comb
    begin
        start_day = (item.day_a == '0) ? DAY_W'(1) : item.day_a;
        if (32'(item.add_count) > 32'(MAX_ADD_DAYS))
            cnt_sat = TW'(MAX_ADD_DAYS);
        else
            cnt_sat = TW'(item.add_count);
        total_init = TW'(start_day) + cnt_sat;
    end

    // Leap test from the tracked year position within its century
    assign leap = (rem100_reg == '0) ? (q4_reg == 2'd0) : (yr_reg[1:0] == 2'd0);

    gda_alu #(
        .W (AW)
    ) u_alu (
        .a      (acc_reg),
        .b      (alu_b),
        .sub    (alu_sub),
        .result (alu_result),
        .borrow (alu_borrow),
        .zero   (alu_zero)
    );

    gda_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .res      (div_res)
    );

    // Keep stepping while the total exceeds the current month
    assign step_go = !alu_borrow && !alu_zero;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = (item.func == FUNC_ADD) ? S_A_DIVS : S_D_MUL;
            end
            S_D_MUL:  state_next = S_D_DAY;
            S_D_DAY:  state_next = S_D_Q4;
            S_D_Q4:   state_next = S_D_DIVS;
            S_D_DIVS: state_next = S_D_DIVW;
            S_D_DIVW:
            begin
                if (div_res.done)
                    state_next = S_D_Q100;
            end
            S_D_Q100: state_next = S_D_Q400;
            S_D_Q400: state_next = sel_b_reg ? S_FINISH : S_D_MUL;
            S_A_DIVS: state_next = S_A_DIVW;
            S_A_DIVW:
            begin
                if (div_res.done)
                    state_next = S_A_STEP;
            end
            S_A_STEP:
            begin
                if (!step_go)
                    state_next = S_FINISH;
            end
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: adder operand and divider launch
    always_comb
    begin
        alu_b        = '0;
        alu_sub      = 1'b0;
        div_start    = 1'b0;
        div_dividend = ly;
        case (state_reg)
            S_D_MUL:
            begin
                alu_b   = AW'(cur_y) * AW'(DAYS_PER_YEAR);
                alu_sub = sel_b_reg;
            end
            S_D_DAY:
            begin
                alu_b   = AW'(cur_d) + AW'(month_start(cur_m));
                alu_sub = sel_b_reg;
            end
            S_D_Q4:
            begin
                alu_b   = AW'(ly[YEAR_W-1:2]);
                alu_sub = sel_b_reg;
            end
            S_D_DIVS:
            begin
                div_start = 1'b1;
            end
            S_D_Q100:
            begin
                alu_b   = AW'(div_res.quotient);
                alu_sub = !sel_b_reg;
            end
            S_D_Q400:
            begin
                alu_b   = AW'(div_res.quotient[DIV_W-1:2]);
                alu_sub = sel_b_reg;
            end
            S_A_DIVS:
            begin
                div_start    = 1'b1;
                div_dividend = req_reg.year_a;
            end
            S_A_STEP:
            begin
                alu_b   = AW'(month_len(mon_reg, leap));
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_b_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINISH);
            if (accept)
                sel_b_reg <= 1'b0;
            else if (state_reg == S_D_Q400)
                sel_b_reg <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= item;
            acc_reg <= (item.func == FUNC_ADD) ? AW'(total_init) : '0;
            yr_reg  <= YW'(item.year_a);
            mon_reg <= clamp_month(item.month_a);
            le_reg  <= ({item.year_a, item.month_a, item.day_a}
                        <= {item.year_b, item.month_b, item.day_b});
        end

        case (state_reg)
            S_D_MUL, S_D_DAY, S_D_Q4, S_D_Q100, S_D_Q400:
            begin
                acc_reg <= alu_result;
            end
            S_A_DIVW:
            begin
                if (div_res.done)
                begin
                    rem100_reg <= div_res.remainder;
                    q4_reg     <= div_res.quotient[1:0];
                end
            end
            S_A_STEP:
            begin
                // Drop the month and advance the date
                if (step_go)
                begin
                    acc_reg <= alu_result;
                    if (mon_reg == MONTH_DEC)
                    begin
                        mon_reg <= MONTH_JAN;
                        yr_reg  <= yr_reg + 1'b1;
                        if (rem100_reg == REM_LAST)
                        begin
                            rem100_reg <= '0;
                            q4_reg     <= q4_reg + 1'b1;
                        end
                        else
                        begin
                            rem100_reg <= rem100_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        mon_reg <= mon_reg + 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (req_reg.func == FUNC_ADD)
                begin
                    res_reg.day_diff      <= '0;
                    res_reg.a_not_after_b <= 1'b0;
                    res_reg.sum_year      <= yr_reg[YEAR_W-1:0];
                    res_reg.sum_month     <= mon_reg;
                    res_reg.sum_day       <= acc_reg[DAY_W-1:0];
                end
                else
                begin
                    res_reg.day_diff      <= acc_reg[DIFF_W-1:0];
                    res_reg.a_not_after_b <= le_reg;
                    res_reg.sum_year      <= '0;
                    res_reg.sum_month     <= '0;
                    res_reg.sum_day       <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ hw/rtl/gda_divider.sv @@
module gda_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gda_pkg::DIV_W-1:0]  dividend,
    output gda_pkg::div_res_t          res
);
    import gda_pkg::*;

    logic [DIV_W-1:0]  quo_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              done_reg;

    logic [PROD_W-1:0] prod;
    logic [DIV_W-1:0]  quo_next;
    logic [DIV_W-1:0]  back;
    logic [DIV_W-1:0]  rem_full;

    // Multiply by the scaled reciprocal, then recover the remainder
    always_comb
    begin
        prod     = PROD_W'(dividend) * PROD_W'(RECIP);
        quo_next = DIV_W'(prod >> RECIP_SHIFT);
        back     = quo_next * DIV_W'(DIVISOR);
        rem_full = dividend - back;
    end

    // Control: pulse done the cycle after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    // Datapath: capture quotient and remainder on start, hold until the next one
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_full[REM_W-1:0];
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

@@ hw/rtl/gda_alu.sv @@
module gda_alu #(
    parameter int W = 23
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] result,
    output logic         borrow,
    output logic         zero
);
    logic [W:0] wide;

    // Add or subtract, keeping the carry out as borrow on subtract
    always_comb
    begin
        if (sub)
            wide = {1'b0, a} - {1'b0, b};
        else
            wide = {1'b0, a} + {1'b0, b};
        result = wide[W-1:0];
        borrow = sub & wide[W];
        zero   = (wide[W-1:0] == '0);
    end

endmodule

@@ hw/rtl/gda_checker.sv @@
`include "assert_macros.svh"

module gda_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input gda_pkg::gda_out_t result
);
    import gda_pkg::*;

    logic taken;
    logic add_shape;
    logic diff_shape;

    assign taken      = start && !busy;
    assign add_shape  = (result.sum_month != '0) && (result.day_diff == '0)
                        && !result.a_not_after_b;
    assign diff_shape = (result.sum_month == '0) && (result.sum_year == '0)
                        && (result.sum_day == '0);

    // A transfer in starts work at once
    `ASSERT_NEXT(a_take_busy, clk, rst_n, taken, busy)
    // A result lasts one cycle
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // Results appear only once the unit is free again
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done, !busy)
    // Only the fields of one operation carry data
    `ASSERT_IMPLIES(a_done_shape, clk, rst_n, done, add_shape || diff_shape)

endmodule

bind gregorian_date_arithmetic_top gda_checker u_gda_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
